/* sv/addressed_frame_crc8_receiver_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros for the frame receiver.
// ----------------------------------------------------------------------------
`ifndef ADDRESSED_FRAME_CRC8_RECEIVER_ASSERT_SVH
`define ADDRESSED_FRAME_CRC8_RECEIVER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define AFCR_ASSERT_IMPLY(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

`define AFCR_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`else

`define AFCR_ASSERT_IMPLY(label, clk, rst, cond, prop, msg)

`define AFCR_ASSERT_NEXT(label, clk, rst, cond, prop, msg)

`endif

`endif

/* sv/afcr_pkg.sv */
// ----------------------------------------------------------------------------
// afcr_pkg
// Types, constants and the CRC-8 byte update for the frame receiver.
// ----------------------------------------------------------------------------
package afcr_pkg;

  localparam logic [7:0]  CRC_POLY          = 8'h8C;
  localparam logic [7:0]  NODE_ADDRESS_INIT = 8'h01;
  localparam logic [15:0] COMPARE_VALUE_INIT = 16'd3000;
  localparam logic [1:0]  FRAME_LAST        = 2'd3;

  localparam int unsigned INDEX_WIDTH = 2;
  localparam int unsigned DATA_WIDTH  = 16;

  localparam logic [INDEX_WIDTH-1:0] REG_NODE_ADDRESS  = 2'd0;
  localparam logic [INDEX_WIDTH-1:0] REG_COMPARE_VALUE = 2'd1;

  typedef struct packed {
    logic [1:0] byte_position;
    logic [7:0] running_crc;
    logic [7:0] address_byte;
    logic [7:0] setpoint_high;
    logic [7:0] setpoint_low;
  } frame_state_t;

  typedef struct packed {
    logic        frame_accepted;
    logic        address_ok;
    logic        crc_ok;
    logic [15:0] setpoint;
    logic        setpoint_matches;
  } result_t;

  function automatic logic [7:0] crc8_feed(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] crc;
    logic [7:0] b;
    logic       fb;
    crc = crc_in;
    b   = data;
    for (int i = 0; i < 8; i++) begin
      fb  = crc[0] ^ b[0];
      crc = {1'b0, crc[7:1]};
      if (fb) begin
        crc = crc ^ CRC_POLY;
      end
      b = {1'b0, b[7:1]};
    end
    return crc;
  endfunction

endpackage

/* sv/afcr_if.sv */
// ----------------------------------------------------------------------------
// afcr_if
// Valid/ready channel interfaces for received bytes and frame results.
// ----------------------------------------------------------------------------
interface afcr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface afcr_result_if;
  logic        valid;
  logic        ready;
  logic        frame_accepted;
  logic        address_ok;
  logic        crc_ok;
  logic [15:0] setpoint;
  logic        setpoint_matches;

  modport source (
    output valid, output frame_accepted, output address_ok, output crc_ok,
    output setpoint, output setpoint_matches, input ready
  );
  modport sink (
    input valid, input frame_accepted, input address_ok, input crc_ok,
    input setpoint, input setpoint_matches, output ready
  );
endinterface

/* sv/afcr_frame.sv */
// ----------------------------------------------------------------------------
// afcr_frame
// Frame assembly step: folds one byte into the frame state and forms the
// result when the byte closes a frame.
// ----------------------------------------------------------------------------
module afcr_frame (
  input  afcr_pkg::frame_state_t state,
  input  logic [7:0]             data,
  input  logic [7:0]             node_address,
  input  logic [15:0]            compare_value,
  output afcr_pkg::frame_state_t state_next,
  output logic                   has_result,
  output afcr_pkg::result_t      result
);
  import afcr_pkg::*;

  logic [15:0] sp;

  assign sp         = {state.setpoint_high, state.setpoint_low};
  assign has_result = (state.byte_position == FRAME_LAST);

  always_comb begin
    result.address_ok       = (state.address_byte == node_address);
    result.crc_ok           = (state.running_crc == data);
    result.frame_accepted   = result.address_ok && result.crc_ok;
    result.setpoint         = sp;
    result.setpoint_matches = result.frame_accepted && (sp == compare_value);
  end

  always_comb begin
    state_next = state;
    if (has_result) begin
      state_next = '0;
    end else begin
      case (state.byte_position)
        2'd0:    state_next.address_byte  = data;
        2'd1:    state_next.setpoint_high = data;
        default: state_next.setpoint_low  = data;
      endcase
      state_next.running_crc   = crc8_feed(state.running_crc, data);
      state_next.byte_position = state.byte_position + 2'd1;
    end
  end

endmodule

/* sv/addressed_frame_crc8_receiver.sv */
// ----------------------------------------------------------------------------
// addressed_frame_crc8_receiver
// Groups received bytes into four-byte frames (address, setpoint high,
// setpoint low, CRC-8) and reports address, CRC and setpoint checks.
//
//   Channel   Direction  Transaction
//   rx        in         one received byte
//   result    out        one frame report, on every fourth byte
//   wr_*      in         register write, index 0 node address, 1 compare
//
// A byte is taken into an input register, then folded into the frame state;
// the fourth byte loads the result register. One byte per cycle is sustained
// while the result channel is not stalled; the report is valid from the result
// register once the fourth byte moves out of the input register.
// Reset clears the frame state and restores the register defaults.
// A stalled result holds its register and the input register waits behind it.
// ----------------------------------------------------------------------------
module addressed_frame_crc8_receiver (
  input  logic                                clk,
  input  logic                                rst,
  afcr_rx_if.sink                             rx,
  afcr_result_if.source                       result,
  input  logic                                wr_en,
  input  logic [afcr_pkg::INDEX_WIDTH-1:0]    wr_index,
  input  logic [afcr_pkg::DATA_WIDTH-1:0]     wr_data
);
  import afcr_pkg::*;

`include "addressed_frame_crc8_receiver_assert.svh"

  logic [7:0]   node_address;
  logic [15:0]  compare_value;

  logic         in_valid;
  logic [7:0]   in_byte;
  logic         in_move;

  frame_state_t state;
  frame_state_t state_next;
  logic         has_result;
  result_t      res_next;

  logic         out_valid;
  result_t      out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_address  <= NODE_ADDRESS_INIT;
      compare_value <= COMPARE_VALUE_INIT;
    end else if (wr_en) begin
      case (wr_index)
        REG_NODE_ADDRESS:  node_address  <= wr_data[7:0];
        REG_COMPARE_VALUE: compare_value <= wr_data;
        default:           ;
      endcase
    end
  end

  assign in_move  = in_valid && (!out_valid || result.ready);
  assign rx.ready = !in_valid || in_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      in_byte <= rx.rx_byte;
    end
  end

  afcr_frame u_frame (
    .state          (state),
    .data           (in_byte),
    .node_address   (node_address),
    .compare_value  (compare_value),
    .state_next     (state_next),
    .has_result     (has_result),
    .result         (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (in_move) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_move && has_result) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_move && has_result) begin
      out_data <= res_next;
    end
  end

  assign result.valid            = out_valid;
  assign result.frame_accepted   = out_data.frame_accepted;
  assign result.address_ok       = out_data.address_ok;
  assign result.crc_ok           = out_data.crc_ok;
  assign result.setpoint         = out_data.setpoint;
  assign result.setpoint_matches = out_data.setpoint_matches;

  `AFCR_ASSERT_IMPLY(a_accept_is_both, clk, rst, out_valid, out_data.frame_accepted == (out_data.address_ok && out_data.crc_ok), "frame_accepted disagrees with the checks")
  `AFCR_ASSERT_IMPLY(a_match_needs_accept, clk, rst, out_valid && out_data.setpoint_matches, out_data.frame_accepted, "setpoint match on a rejected frame")
  `AFCR_ASSERT_NEXT(a_frame_end_clears, clk, rst, in_move && has_result, state == '0 && out_valid, "frame end did not clear state or raise a result")
  `AFCR_ASSERT_NEXT(a_no_result_mid_frame, clk, rst, in_move && !has_result && !out_valid, !out_valid, "result raised before the frame ended")

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives received bytes into the frame receiver as well-formed, broken and
// stray frames under several register settings, and checks every frame
// report against a predictor kept in the testbench, with random idling on
// both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  import afcr_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned DRAIN_CYCLES   = 10;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned RANDOM_PHASES  = 8;
  localparam int unsigned PHASE_BYTES    = 228;
  localparam int unsigned REPORT_LIMIT   = 10;

  localparam logic [INDEX_WIDTH-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [INDEX_WIDTH-1:0] REG_SPARE_3 = 2'd3;

  localparam logic [1:0] POS_ADDRESS  = 2'd0;
  localparam logic [1:0] POS_SET_HIGH = 2'd1;

  logic clk = 1'b0;
  logic rst;
  logic wr_en;
  logic [INDEX_WIDTH-1:0] wr_index;
  logic [DATA_WIDTH-1:0]  wr_data;

  afcr_rx_if     rx_ch ();
  afcr_result_if res_ch ();

  addressed_frame_crc8_receiver dut (
    .clk      (clk),
    .rst      (rst),
    .rx       (rx_ch),
    .result   (res_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state and its copy of the registers.
  logic [7:0]  mdl_dev;
  logic [15:0] mdl_cmp;
  logic [1:0]  mdl_pos;
  logic [7:0]  mdl_crc;
  logic [7:0]  mdl_addr;
  logic [7:0]  mdl_hi;
  logic [7:0]  mdl_lo;

  result_t pending_reports[$];

  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;

  // Stimulus-side view of the registers and the frame position.
  logic [7:0]  cur_dev;
  logic [15:0] cur_cmp;
  logic [1:0]  sent_pos;
  bit          quiet_phase;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] value);
    logic [7:0] acc;
    acc = crc;
    for (int i = 0; i < 8; i++) begin
      if (acc[0] ^ value[i]) acc = (acc >> 1) ^ CRC_POLY;
      else acc = acc >> 1;
    end
    return acc;
  endfunction

  task fold_rx_byte(input logic [7:0] value);
    result_t rep;
    if (mdl_pos != FRAME_LAST) begin
      case (mdl_pos)
        POS_ADDRESS: begin
          mdl_addr = value;
        end
        POS_SET_HIGH: begin
          mdl_hi = value;
        end
        default: begin
          mdl_lo = value;
        end
      endcase
      mdl_crc = crc8_step(mdl_crc, value);
      mdl_pos = mdl_pos + 2'd1;
    end else begin
      rep.address_ok       = (mdl_addr == mdl_dev);
      rep.crc_ok           = (mdl_crc == value);
      rep.frame_accepted   = rep.address_ok && rep.crc_ok;
      rep.setpoint         = {mdl_hi, mdl_lo};
      rep.setpoint_matches = rep.frame_accepted && (rep.setpoint == mdl_cmp);
      pending_reports.push_back(rep);
      mdl_pos  = POS_ADDRESS;
      mdl_crc  = 8'h00;
      mdl_addr = 8'h00;
      mdl_hi   = 8'h00;
      mdl_lo   = 8'h00;
    end
  endtask

  task check_report();
    result_t want;
    if (pending_reports.size() == 0) begin
      if (fail_count < REPORT_LIMIT) begin
        $display("unexpected report: acc=%0b addr=%0b crc=%0b sp=%0d match=%0b",
                 res_ch.frame_accepted, res_ch.address_ok, res_ch.crc_ok,
                 res_ch.setpoint, res_ch.setpoint_matches);
      end
      fail_count++;
    end else begin
      want = pending_reports.pop_front();
      if (res_ch.frame_accepted !== want.frame_accepted ||
          res_ch.address_ok !== want.address_ok ||
          res_ch.crc_ok !== want.crc_ok ||
          res_ch.setpoint !== want.setpoint ||
          res_ch.setpoint_matches !== want.setpoint_matches) begin
        if (fail_count < REPORT_LIMIT) begin
          $display("report mismatch: expected acc=%0b addr=%0b crc=%0b sp=%0d match=%0b",
                   want.frame_accepted, want.address_ok, want.crc_ok,
                   want.setpoint, want.setpoint_matches);
          $display("                 actual   acc=%0b addr=%0b crc=%0b sp=%0d match=%0b",
                   res_ch.frame_accepted, res_ch.address_ok, res_ch.crc_ok,
                   res_ch.setpoint, res_ch.setpoint_matches);
        end
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mdl_dev  = NODE_ADDRESS_INIT;
      mdl_cmp  = COMPARE_VALUE_INIT;
      mdl_pos  = POS_ADDRESS;
      mdl_crc  = 8'h00;
      mdl_addr = 8'h00;
      mdl_hi   = 8'h00;
      mdl_lo   = 8'h00;
    end else begin
      if (res_ch.valid && res_ch.ready) check_report();
      if (rx_ch.valid && rx_ch.ready) fold_rx_byte(rx_ch.rx_byte);
      if (wr_en) begin
        if (wr_index == REG_NODE_ADDRESS) mdl_dev = wr_data[7:0];
        else if (wr_index == REG_COMPARE_VALUE) mdl_cmp = wr_data[15:0];
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  always @(negedge clk) begin
    res_ch.ready = quiet_phase || ($urandom_range(0, 99) >= 33);
  end

  task automatic send_byte(input logic [7:0] value);
    while (!quiet_phase && $urandom_range(0, 99) < 33) begin
      rx_ch.valid = 1'b0;
      @(negedge clk);
    end
    rx_ch.valid   = 1'b1;
    rx_ch.rx_byte = value;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    sent_pos = sent_pos + 2'd1;
    @(negedge clk);
  endtask

  task automatic send_frame(input logic [7:0] addr, input logic [15:0] sp, input bit bad_crc);
    logic [7:0] crc;
    crc = crc8_step(crc8_step(crc8_step(8'h00, addr), sp[15:8]), sp[7:0]);
    if (bad_crc) crc = crc ^ 8'($urandom_range(1, 255));
    send_byte(addr);
    send_byte(sp[15:8]);
    send_byte(sp[7:0]);
    send_byte(crc);
  endtask

  // Lowers valid and lets every outstanding transaction, and any byte still
  // being folded into a partial frame, clear the block.
  task automatic wait_idle();
    rx_ch.valid = 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apply_register(input logic [INDEX_WIDTH-1:0] index,
                                input logic [DATA_WIDTH-1:0] value);
    wr_en    = 1'b1;
    wr_index = index;
    wr_data  = value;
    @(negedge clk);
    wr_en = 1'b0;
    @(negedge clk);
    if (index == REG_NODE_ADDRESS) cur_dev = value[7:0];
    else if (index == REG_COMPARE_VALUE) cur_cmp = value;
  endtask

  task automatic test_default_registers();
    send_frame(cur_dev, cur_cmp, 1'b0);
    send_frame(cur_dev, cur_cmp - 16'd1, 1'b0);
    send_frame(cur_dev + 8'd1, cur_cmp, 1'b0);
    send_frame(cur_dev, cur_cmp, 1'b1);
  endtask

  task automatic test_register_extremes();
    wait_idle();
    // The upper byte of the data is not part of the address register.
    apply_register(REG_NODE_ADDRESS, 16'hFF00);
    apply_register(REG_COMPARE_VALUE, 16'h0000);
    apply_register(REG_SPARE_2, 16'h1234);
    send_frame(8'h00, 16'h0000, 1'b0);
    wait_idle();
    apply_register(REG_NODE_ADDRESS, 16'h00FF);
    apply_register(REG_COMPARE_VALUE, 16'hFFFF);
    apply_register(REG_SPARE_3, 16'hFFFF);
    send_frame(8'hFF, 16'hFFFF, 1'b0);
  endtask

  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned pick;
    logic [7:0]  addr;
    logic [15:0] sp;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      if (p == 0) begin
        apply_register(REG_NODE_ADDRESS, 16'h0000);
        apply_register(REG_COMPARE_VALUE, 16'h0000);
      end else if (p == 1) begin
        apply_register(REG_NODE_ADDRESS, 16'hFFFF);
        apply_register(REG_COMPARE_VALUE, 16'hFFFF);
      end else begin
        apply_register(REG_NODE_ADDRESS, 16'($urandom_range(0, 65535)));
        apply_register(REG_COMPARE_VALUE, 16'($urandom_range(0, 65535)));
        if ($urandom_range(0, 3) == 0) begin
          apply_register($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                         16'($urandom_range(0, 65535)));
        end
      end
      quiet_phase = (p == 3);
      sent = 0;
      while (sent < PHASE_BYTES) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          while (sent_pos != POS_ADDRESS) begin
            send_byte(8'($urandom_range(0, 255)));
            sent++;
          end
          addr = ($urandom_range(0, 99) < 70) ? cur_dev : 8'($urandom_range(0, 255));
          pick = $urandom_range(0, 99);
          if (pick < 25) sp = cur_cmp;
          else if (pick < 30) sp = 16'h0000;
          else if (pick < 35) sp = 16'hFFFF;
          else sp = 16'($urandom_range(0, 65535));
          send_frame(addr, sp, $urandom_range(0, 99) < 20);
          sent += 4;
        end else if (pick < 90) begin
          repeat (4) send_byte(8'($urandom_range(0, 255)));
          sent += 4;
        end else begin
          send_byte(8'($urandom_range(0, 255)));
          sent++;
        end
      end
      quiet_phase = 1'b0;
    end
  endtask

  initial begin
    rst           = 1'b1;
    wr_en         = 1'b0;
    wr_index      = '0;
    wr_data       = '0;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = 8'h00;
    quiet_phase   = 1'b0;
    sent_pos      = POS_ADDRESS;
    cur_dev       = NODE_ADDRESS_INIT;
    cur_cmp       = COMPARE_VALUE_INIT;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_default_registers();
    test_register_extremes();
    test_random_traffic();

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending_reports.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/afcr_pkg.sv
sv/afcr_if.sv
sv/afcr_frame.sv
sv/addressed_frame_crc8_receiver.sv
sim/tb_top.sv
